// ===== rtl/tbp_pkg.sv =====
// Shared types, constants and the counter training function of the tournament predictor.
package tbp_pkg;

    // Field widths and stream packing.
    localparam int BRANCH_INDEX_W = 11;
    localparam int IN_TDATA_W     = 16;
    localparam int OUT_TDATA_W    = 8;
    localparam int HIST_LEN_W     = 4;

    // History length after reset.
    localparam logic [HIST_LEN_W-1:0] HIST_LEN_RESET = 4'd11;

    // Two-bit saturating counter values.
    typedef logic [1:0] ctr_t;
    localparam ctr_t CTR_MIN           = 2'd0;
    localparam ctr_t CTR_MAX           = 2'd3;
    localparam ctr_t CTR_STRONG_TAKEN  = 2'd3;
    localparam ctr_t CTR_STRONG_GSHARE = 2'd0;

    // Back-end sequencer states.
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_FETCH,
        ST_EVAL
    } back_state_t;

    // One result; the first member listed is the highest bit.
    typedef struct packed {
        logic chosen_correct;
        logic used_bimodal;
        logic chosen_guess;
        logic gshare_guess;
        logic bimodal_guess;
    } result_t;

    localparam int OUT_PAD_W = OUT_TDATA_W - $bits(result_t);

    // Saturating increment when up is set, saturating decrement otherwise.
    function automatic ctr_t train(ctr_t c, logic up);
        ctr_t r;
        if (up)
            r = (c == CTR_MAX) ? CTR_MAX : c + 2'd1;
        else
            r = (c == CTR_MIN) ? CTR_MIN : c - 2'd1;
        return r;
    endfunction

endpackage

// ===== rtl/tbp_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module tbp_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
            mem_reg[waddr] <= wdata;
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/tbp_queue.sv =====
// Two-entry queue that decouples the front end from the table back end.
module tbp_queue #(
    parameter int WIDTH = 23
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    localparam int QDEPTH = 2;
    localparam int PTR_W  = $clog2(QDEPTH);
    localparam int CNT_W  = $clog2(QDEPTH + 1);

    logic [WIDTH-1:0] slot_reg [QDEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(QDEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// ===== rtl/tbp_front.sv =====
// Front end: accepts branches, keeps the global history and forms the gshare index.
module tbp_front #(
    parameter int INDEX_BITS = 11
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [tbp_pkg::HIST_LEN_W-1:0]    cfg_wr_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [tbp_pkg::IN_TDATA_W-1:0]    s_data,
    input  logic                              clearing,
    output logic                              q_valid,
    input  logic                              q_ready,
    output logic [2*INDEX_BITS:0]             q_data
);

    import tbp_pkg::*;

    logic [HIST_LEN_W-1:0] hist_len_reg;
    logic [INDEX_BITS-1:0] history_reg, history_next;
    logic [INDEX_BITS-1:0] hmask;
    logic [INDEX_BITS-1:0] addr;
    logic [INDEX_BITS-1:0] gidx;
    logic                  taken;
    logic                  accept;

    // Unpack the request; address bits above the table size are dropped.
    assign addr  = INDEX_BITS'(s_data[BRANCH_INDEX_W-1:0]);
    assign taken = s_data[BRANCH_INDEX_W];

    // No request is taken while the tables are being cleared.
    assign s_ready = !clearing && q_ready;
    assign q_valid = s_valid && !clearing;
    assign accept  = s_valid && s_ready;

    // History mask: bit i is kept when the configured length exceeds i.
    always_comb
    begin
        for (int i = 0; i < INDEX_BITS; i++)
            hmask[i] = (int'(hist_len_reg) > i);
    end

    assign gidx   = addr ^ (history_reg & hmask);
    assign q_data = {taken, gidx, addr};

    // Newest outcome enters at bit 0.
    assign history_next = {history_reg[INDEX_BITS-2:0], taken};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            history_reg  <= '0;
            hist_len_reg <= HIST_LEN_RESET;
        end
        else
        begin
            if (accept)
                history_reg <= history_next;
            if (cfg_wr_en)
                hist_len_reg <= cfg_wr_data;
        end
    end

endmodule

// ===== rtl/tbp_back.sv =====
// Back end: clears the tables, then reads, trains and writes them back per branch.
module tbp_back #(
    parameter int INDEX_BITS = 11
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    output logic                  q_ready,
    input  logic [2*INDEX_BITS:0] q_data,
    output logic                  clearing,
    output logic                  m_valid,
    input  logic                  m_ready,
    output tbp_pkg::result_t      m_result
);

    import tbp_pkg::*;

    localparam int DEPTH = 1 << INDEX_BITS;

    back_state_t           state_reg, state_next;
    logic [INDEX_BITS-1:0] clr_addr_reg;
    logic [2*INDEX_BITS:0] item_reg;
    logic                  out_valid_reg, out_valid_next;
    result_t               out_data_reg;

    logic [INDEX_BITS-1:0] item_addr, item_gidx, raddr_bc, raddr_g;
    logic [INDEX_BITS-1:0] waddr_bc, waddr_g;
    logic                  item_taken;
    logic [3:0]            bc_rdata, bc_wdata;
    ctr_t                  g_rdata, g_wdata;
    logic                  ram_we;
    logic                  pop;
    logic                  load_out;
    logic                  out_free;
    logic                  clr_last;

    ctr_t    bi_ctr, ch_ctr, bi_new, gs_new, ch_new;
    logic    bi_guess, gs_guess, use_bi, chosen;
    result_t result;

    assign item_addr  = item_reg[INDEX_BITS-1:0];
    assign item_gidx  = item_reg[2*INDEX_BITS-1:INDEX_BITS];
    assign item_taken = item_reg[2*INDEX_BITS];
    assign out_free   = !out_valid_reg || m_ready;
    assign clr_last   = (clr_addr_reg == '1);

    // Read the queue head when fetching, otherwise hold on the current item.
    assign raddr_bc = (state_reg == ST_FETCH) ? q_data[INDEX_BITS-1:0] : item_addr;
    assign raddr_g  = (state_reg == ST_FETCH) ? q_data[2*INDEX_BITS-1:INDEX_BITS] : item_gidx;

    // Bimodal counter in the low half, chooser counter in the high half.
    tbp_ram #(.WIDTH(4), .DEPTH(DEPTH)) u_bc_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (waddr_bc),
        .wdata (bc_wdata),
        .raddr (raddr_bc),
        .rdata (bc_rdata)
    );

    tbp_ram #(.WIDTH(2), .DEPTH(DEPTH)) u_gs_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (waddr_g),
        .wdata (g_wdata),
        .raddr (raddr_g),
        .rdata (g_rdata)
    );

    // Predictions come from the counter MSBs; train bimodal and gshare, and the chooser on disagreement.
    always_comb
    begin
        bi_ctr   = bc_rdata[1:0];
        ch_ctr   = bc_rdata[3:2];
        bi_guess = bi_ctr[1];
        gs_guess = g_rdata[1];
        use_bi   = ch_ctr[1];
        chosen   = use_bi ? bi_guess : gs_guess;
        bi_new   = train(bi_ctr, item_taken);
        gs_new   = train(g_rdata, item_taken);
        ch_new   = (bi_guess != gs_guess) ? train(ch_ctr, bi_guess == item_taken) : ch_ctr;
        result.bimodal_guess  = bi_guess;
        result.gshare_guess   = gs_guess;
        result.chosen_guess   = chosen;
        result.used_bimodal   = use_bi;
        result.chosen_correct = (chosen == item_taken);
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
                if (clr_last)
                    state_next = ST_FETCH;
            ST_FETCH:
                if (q_valid)
                    state_next = ST_EVAL;
            ST_EVAL:
                if (out_free)
                    state_next = ST_FETCH;
            default:
                state_next = ST_CLEAR;
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        pop      = 1'b0;
        load_out = 1'b0;
        ram_we   = 1'b0;
        waddr_bc = item_addr;
        waddr_g  = item_gidx;
        bc_wdata = {ch_new, bi_new};
        g_wdata  = gs_new;
        clearing = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clearing = 1'b1;
                ram_we   = 1'b1;
                waddr_bc = clr_addr_reg;
                waddr_g  = clr_addr_reg;
                bc_wdata = {CTR_STRONG_GSHARE, CTR_STRONG_TAKEN};
                g_wdata  = CTR_STRONG_TAKEN;
            end
            ST_FETCH:
                pop = q_valid;
            ST_EVAL:
            begin
                load_out = out_free;
                ram_we   = out_free;
            end
            default:
                clearing = 1'b0;
        endcase
    end

    assign q_ready = pop;

    // Output register valid.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
            out_valid_next = 1'b1;
        else if (m_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (state_reg == ST_CLEAR)
                clr_addr_reg <= clr_addr_reg + INDEX_BITS'(1);
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (pop)
            item_reg <= q_data;
        if (load_out)
            out_data_reg <= result;
    end

    assign m_valid  = out_valid_reg;
    assign m_result = out_data_reg;

endmodule

// ===== rtl/tournament_branch_predictor_core.sv =====
// Top level of the tournament branch predictor: front end, queue and table back end.
//
// Each resolved branch yields one result with the bimodal, gshare and chosen
// predictions, which predictor the selector picked and whether the chosen one
// was right; the bimodal and gshare counter tables are then trained, and the
// chooser table when the two disagree. A branch holds the back end through a
// FETCH state for the registered table read and an EVAL state for the
// train-and-write-back, which waits while the result register is full, so no
// new branch starts before the last is written back. The front end updates the
// history and forms the gshare index on acceptance, and a two-entry queue lets it
// take requests while the back end or the result consumer stalls. After reset a
// clearing pass writes every table entry, during which no request is accepted;
// history_length writes are taken at any time.
module tournament_branch_predictor_core #(
    parameter int INDEX_BITS = 11
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic [tbp_pkg::HIST_LEN_W-1:0]       cfg_wr_data,   // history_length
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [tbp_pkg::IN_TDATA_W-1:0]       s_axis_tdata,  // [10:0] branch_index, [11] taken
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [0] bimodal_guess, [1] gshare_guess, [2] chosen_guess, [3] used_bimodal,
    // [4] chosen_correct
    output logic [tbp_pkg::OUT_TDATA_W-1:0]      m_axis_tdata
);

    import tbp_pkg::*;

    localparam int ITEM_W = 2 * INDEX_BITS + 1;

    logic              clearing;
    logic              fq_valid, fq_ready;
    logic [ITEM_W-1:0] fq_data;
    logic              qb_valid, qb_ready;
    logic [ITEM_W-1:0] qb_data;
    result_t           result;

    tbp_front #(.INDEX_BITS(INDEX_BITS)) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_axis_tvalid),
        .s_ready     (s_axis_tready),
        .s_data      (s_axis_tdata),
        .clearing    (clearing),
        .q_valid     (fq_valid),
        .q_ready     (fq_ready),
        .q_data      (fq_data)
    );

    tbp_queue #(.WIDTH(ITEM_W)) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_data  (fq_data),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_data   (qb_data)
    );

    tbp_back #(.INDEX_BITS(INDEX_BITS)) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (qb_valid),
        .q_ready  (qb_ready),
        .q_data   (qb_data),
        .clearing (clearing),
        .m_valid  (m_axis_tvalid),
        .m_ready  (m_axis_tready),
        .m_result (result)
    );

    assign m_axis_tdata = {OUT_PAD_W'(0), result};

    // No request may be accepted while the tables are being cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !s_axis_tready)
        else $error("request accepted during table clear");

    // No result can be pending when the clearing pass ends.
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(clearing) |-> !m_axis_tvalid)
        else $error("result present at end of table clear");

    // The chosen guess follows the predictor the selector names.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[2] == (m_axis_tdata[3] ? m_axis_tdata[0]
                                                               : m_axis_tdata[1])))
        else $error("chosen guess does not match selected predictor");

endmodule
